// ===== hdl/obs_pkg.sv =====
`timescale 1ns / 1ps
package obs_pkg;

  localparam int MAX_ORDERS = 256;
  localparam int MAX_LEVELS = 64;
  localparam int OIDX_W     = $clog2(MAX_ORDERS);
  localparam int LIDX_W     = $clog2(MAX_LEVELS);
  localparam int SCAN_MAX   = (MAX_ORDERS > MAX_LEVELS) ? MAX_ORDERS : MAX_LEVELS;
  localparam int SCAN_W     = $clog2(SCAN_MAX + 1);
  localparam int LORD_W     = $clog2(MAX_ORDERS + 1);

  localparam int ACT_W      = 2;
  localparam int ID_W       = 32;
  localparam int PRICE_W    = 32;
  localparam int QTY_W      = 32;
  localparam int STAT_W     = 2;
  localparam int VOL_W      = 40;
  localparam int OCNT_W     = 9;
  localparam int LCNT_W     = 7;
  localparam int PADDR_W    = 3;
  localparam int PDATA_W    = 32;

  typedef enum logic [ACT_W-1:0] {
    ACT_INSERT = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_QUERY  = 2'd2,
    ACT_NOP    = 2'd3
  } act_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 2'd0,
    ST_DUP      = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_FULL     = 2'd3
  } stat_e;

  localparam logic [PADDR_W-1:0] REG_BOOK_SIDE = 3'd0;

  typedef struct packed {
    logic [ID_W-1:0]    key;
    logic [PRICE_W-1:0] price;
    logic [QTY_W-1:0]   qty;
  } ord_ent_t;

  typedef struct packed {
    logic [PRICE_W-1:0] price;
    logic [VOL_W-1:0]   vol;
    logic [LORD_W-1:0]  orders;
  } lvl_ent_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic oscan;
    logic lscan;
    logic commit;
    logic bscan;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic       done;
    logic       ord_found;
    logic       ord_free;
    logic [ACT_W-1:0] act;
  } dp_stat_t;

  // a strictly better than b on the given side
  function automatic logic better(input logic [PRICE_W-1:0] a,
                                  input logic [PRICE_W-1:0] b,
                                  input logic side);
    better = side ? (a < b) : (a > b);
  endfunction

endpackage

// ===== hdl/obs_item_if.sv =====
`timescale 1ns / 1ps
interface obs_item_if;
  logic                         valid;
  logic                         ready;
  logic [obs_pkg::ACT_W-1:0]    action;
  logic [obs_pkg::ID_W-1:0]     order_id;
  logic [obs_pkg::PRICE_W-1:0]  price;
  logic [obs_pkg::QTY_W-1:0]    quantity;

  modport source(output valid, action, order_id, price, quantity, input ready);
  modport sink(input valid, action, order_id, price, quantity, output ready);
endinterface

// ===== hdl/obs_result_if.sv =====
`timescale 1ns / 1ps
interface obs_result_if;
  logic                         valid;
  logic                         ready;
  logic [obs_pkg::STAT_W-1:0]   status;
  logic [obs_pkg::PRICE_W-1:0]  best_price;
  logic                         book_empty;
  logic [obs_pkg::VOL_W-1:0]    total_volume;
  logic [obs_pkg::OCNT_W-1:0]   order_count;
  logic [obs_pkg::LCNT_W-1:0]   level_count;
  logic [obs_pkg::VOL_W-1:0]    better_volume;

  modport source(output valid, status, best_price, book_empty, total_volume,
                 order_count, level_count, better_volume, input ready);
  modport sink(input valid, status, best_price, book_empty, total_volume,
               order_count, level_count, better_volume, output ready);
endinterface

// ===== hdl/obs_ram.sv =====
`timescale 1ns / 1ps
module obs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

// ===== hdl/obs_dp.sv =====
`timescale 1ns / 1ps
module obs_dp (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  obs_pkg::dp_cmd_t            cmd_i,
  output obs_pkg::dp_stat_t           stat_o,
  input  logic                        book_side_i,
  input  logic [obs_pkg::ACT_W-1:0]   action_i,
  input  logic [obs_pkg::ID_W-1:0]    order_id_i,
  input  logic [obs_pkg::PRICE_W-1:0] price_i,
  input  logic [obs_pkg::QTY_W-1:0]   quantity_i,
  output logic [obs_pkg::STAT_W-1:0]  status_o,
  output logic [obs_pkg::PRICE_W-1:0] best_price_o,
  output logic                        book_empty_o,
  output logic [obs_pkg::VOL_W-1:0]   total_volume_o,
  output logic [obs_pkg::OCNT_W-1:0]  order_count_o,
  output logic [obs_pkg::LCNT_W-1:0]  level_count_o,
  output logic [obs_pkg::VOL_W-1:0]   better_volume_o
);
  import obs_pkg::*;

  // latched word
  logic [ACT_W-1:0]   act_q;
  logic [ID_W-1:0]    id_q;
  logic [PRICE_W-1:0] price_q;
  logic [QTY_W-1:0]   qty_q;

  // scan sequencing
  logic [SCAN_W-1:0]  cnt_q, cnt_d, scan_n;
  logic               chk_v_q, chk_v_d;
  logic [SCAN_W-1:0]  chk_idx_q, chk_idx_d;
  logic               scanning, done;

  // valid bits
  logic               ord_used_q [MAX_ORDERS];
  logic               lvl_used_q [MAX_LEVELS];

  // scan results
  logic               ofound_q, ofree_q, lfound_q, lfree_q, have_q;
  logic [OIDX_W-1:0]  oidx_q, ofree_idx_q;
  logic [PRICE_W-1:0] oprice_q, best_q;
  logic [QTY_W-1:0]   oqty_q;
  logic [LIDX_W-1:0]  lidx_q, lfree_idx_q;
  logic [VOL_W-1:0]   lvol_q, bvol_q, vol_sum_q;
  logic [LORD_W-1:0]  lord_q;
  logic [OCNT_W-1:0]  orders_held_q;
  logic [LCNT_W-1:0]  levels_held_q;
  logic [STAT_W-1:0]  status_q;

  // memories
  ord_ent_t           ord_rdata, ord_wdata;
  lvl_ent_t           lvl_rdata, lvl_wdata;
  logic               ord_we, lvl_we;
  logic [LIDX_W-1:0]  lvl_waddr;
  logic [OIDX_W-1:0]  oi;
  logic [LIDX_W-1:0]  li;
  logic [PRICE_W-1:0] ltarget;
  logic [VOL_W-1:0]   rem_vol;
  logic [LORD_W-1:0]  rem_ord;
  logic               ins_ok;

  obs_ram #(.WIDTH($bits(ord_ent_t)), .DEPTH(MAX_ORDERS)) u_ord_ram (
    .clk_i   (clk_i),
    .we_i    (ord_we),
    .waddr_i (ofree_idx_q),
    .wdata_i (ord_wdata),
    .raddr_i (cnt_q[OIDX_W-1:0]),
    .rdata_o (ord_rdata)
  );

  obs_ram #(.WIDTH($bits(lvl_ent_t)), .DEPTH(MAX_LEVELS)) u_lvl_ram (
    .clk_i   (clk_i),
    .we_i    (lvl_we),
    .waddr_i (lvl_waddr),
    .wdata_i (lvl_wdata),
    .raddr_i (cnt_q[LIDX_W-1:0]),
    .rdata_o (lvl_rdata)
  );

  // scan address counter, one read issued per cycle
  assign scanning = cmd_i.oscan | cmd_i.lscan | cmd_i.bscan;
  assign scan_n   = cmd_i.oscan ? SCAN_W'(MAX_ORDERS) : SCAN_W'(MAX_LEVELS);
  assign done     = chk_v_q && (chk_idx_q == scan_n - SCAN_W'(1));
  assign oi       = chk_idx_q[OIDX_W-1:0];
  assign li       = chk_idx_q[LIDX_W-1:0];
  assign ltarget  = (act_q == ACT_INSERT) ? price_q : oprice_q;

  always_comb begin
    cnt_d     = cnt_q;
    chk_v_d   = 1'b0;
    chk_idx_d = chk_idx_q;
    if (cmd_i.load || done) begin
      cnt_d = '0;
    end else if (scanning && cnt_q < scan_n) begin
      cnt_d     = cnt_q + SCAN_W'(1);
      chk_v_d   = 1'b1;
      chk_idx_d = cnt_q;
    end
  end

  // commit writes
  assign ins_ok  = lfound_q | lfree_q;
  assign rem_vol = lvol_q - VOL_W'(oqty_q);
  assign rem_ord = lord_q - ((lord_q != '0) ? LORD_W'(1) : LORD_W'(0));

  always_comb begin
    ord_we    = cmd_i.commit && (act_q == ACT_INSERT) && ins_ok;
    ord_wdata = '{key: id_q, price: price_q, qty: qty_q};
    lvl_we    = 1'b0;
    lvl_waddr = lidx_q;
    lvl_wdata = '{price: ltarget, vol: rem_vol, orders: rem_ord};
    if (cmd_i.commit) begin
      if (act_q == ACT_INSERT) begin
        lvl_we    = ins_ok;
        lvl_waddr = lfound_q ? lidx_q : lfree_idx_q;
        lvl_wdata.vol    = (lfound_q ? lvol_q : '0) + VOL_W'(qty_q);
        lvl_wdata.orders = (lfound_q ? lord_q : '0) + LORD_W'(1);
      end else begin
        lvl_we = lfound_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q         <= '0;
      chk_v_q       <= 1'b0;
      chk_idx_q     <= '0;
      vol_sum_q     <= '0;
      orders_held_q <= '0;
      levels_held_q <= '0;
      for (int i = 0; i < MAX_ORDERS; i++) ord_used_q[i] <= 1'b0;
      for (int i = 0; i < MAX_LEVELS; i++) lvl_used_q[i] <= 1'b0;
    end else begin
      cnt_q     <= cnt_d;
      chk_v_q   <= chk_v_d;
      chk_idx_q <= chk_idx_d;
      if (cmd_i.commit) begin
        if (act_q == ACT_INSERT) begin
          if (ins_ok) begin
            ord_used_q[ofree_idx_q] <= 1'b1;
            orders_held_q <= orders_held_q + OCNT_W'(1);
            vol_sum_q     <= vol_sum_q + VOL_W'(qty_q);
            if (!lfound_q) begin
              lvl_used_q[lfree_idx_q] <= 1'b1;
              levels_held_q <= levels_held_q + LCNT_W'(1);
            end
          end
        end else begin
          ord_used_q[oidx_q] <= 1'b0;
          if (orders_held_q != '0) orders_held_q <= orders_held_q - OCNT_W'(1);
          vol_sum_q <= vol_sum_q - VOL_W'(oqty_q);
          if (lfound_q && rem_ord == '0) begin
            lvl_used_q[lidx_q] <= 1'b0;
            if (levels_held_q != '0) levels_held_q <= levels_held_q - LCNT_W'(1);
          end
        end
      end
    end
  end

  // item latch and scan results
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      act_q    <= action_i;
      id_q     <= order_id_i;
      price_q  <= price_i;
      qty_q    <= quantity_i;
      ofound_q <= 1'b0;
      ofree_q  <= 1'b0;
      lfound_q <= 1'b0;
      lfree_q  <= 1'b0;
      have_q   <= 1'b0;
      best_q   <= '0;
      bvol_q   <= '0;
      status_q <= ST_OK;
    end else begin
      // order table: id match and lowest free slot
      if (cmd_i.oscan && chk_v_q) begin
        if (ord_used_q[oi] && ord_rdata.key == id_q && !ofound_q) begin
          ofound_q <= 1'b1;
          oidx_q   <= oi;
          oprice_q <= ord_rdata.price;
          oqty_q   <= ord_rdata.qty;
        end
        if (!ord_used_q[oi] && !ofree_q) begin
          ofree_q     <= 1'b1;
          ofree_idx_q <= oi;
        end
      end
      if (cmd_i.oscan && done) begin
        if (act_q == ACT_INSERT) begin
          if (ofound_q || (ord_used_q[oi] && ord_rdata.key == id_q)) status_q <= ST_DUP;
          else if (!ofree_q && !(!ord_used_q[oi])) status_q <= ST_FULL;
        end else if (!ofound_q && !(ord_used_q[oi] && ord_rdata.key == id_q)) begin
          status_q <= ST_NOTFOUND;
        end
      end
      // level table: price match and lowest free slot
      if (cmd_i.lscan && chk_v_q) begin
        if (lvl_used_q[li] && lvl_rdata.price == ltarget && !lfound_q) begin
          lfound_q <= 1'b1;
          lidx_q   <= li;
          lvol_q   <= lvl_rdata.vol;
          lord_q   <= lvl_rdata.orders;
        end
        if (!lvl_used_q[li] && !lfree_q) begin
          lfree_q     <= 1'b1;
          lfree_idx_q <= li;
        end
      end
      if (cmd_i.commit && act_q == ACT_INSERT && !ins_ok) begin
        status_q <= ST_FULL;
      end
      // best price and better volume
      if (cmd_i.bscan && chk_v_q && lvl_used_q[li]) begin
        if (!have_q || better(lvl_rdata.price, best_q, book_side_i)) begin
          best_q <= lvl_rdata.price;
          have_q <= 1'b1;
        end
        if (act_q == ACT_QUERY && better(lvl_rdata.price, price_q, book_side_i)) begin
          bvol_q <= bvol_q + lvl_rdata.vol;
        end
      end
    end
  end

  // status to controller; the last compared entry counts at the done cycle
  assign stat_o.done      = done;
  assign stat_o.ord_found = ofound_q | (ord_used_q[oi] && ord_rdata.key == id_q);
  assign stat_o.ord_free  = ofree_q | !ord_used_q[oi];
  assign stat_o.act       = act_q;

  assign status_o        = status_q;
  assign best_price_o    = best_q;
  assign book_empty_o    = !have_q;
  assign total_volume_o  = vol_sum_q;
  assign order_count_o   = orders_held_q;
  assign level_count_o   = levels_held_q;
  assign better_volume_o = bvol_q;

  // checks
  a_chk_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    chk_v_q |-> chk_idx_q < scan_n)
    else $error("scan index past table end");
  a_done_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |=> !chk_v_q)
    else $error("scan did not restart after done");
  a_orders_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(orders_held_q) <= MAX_ORDERS)
    else $error("order count beyond table size");
  a_levels_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(levels_held_q) <= MAX_LEVELS)
    else $error("level count beyond table size");
endmodule

// ===== hdl/obs_ctrl.sv =====
`timescale 1ns / 1ps
module obs_ctrl (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  input  logic [obs_pkg::ACT_W-1:0] in_action_i,
  output logic                      in_ready_o,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output obs_pkg::dp_cmd_t          cmd_o,
  input  obs_pkg::dp_stat_t         stat_i
);
  import obs_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_OSCAN, S_LSCAN, S_COMMIT, S_BSCAN, S_OUT
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   accept, skip_lvl;

  assign accept = in_valid_i && (state_q == S_IDLE);

  // rejected insert or remove goes straight to the snapshot
  assign skip_lvl = (stat_i.act == ACT_INSERT) ?
                    (stat_i.ord_found || !stat_i.ord_free) : !stat_i.ord_found;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            state_q <= (in_action_i == ACT_INSERT || in_action_i == ACT_REMOVE) ?
                       S_OSCAN : S_BSCAN;
          end
        end
        S_OSCAN: begin
          if (stat_i.done) state_q <= skip_lvl ? S_BSCAN : S_LSCAN;
        end
        S_LSCAN: begin
          if (stat_i.done) state_q <= S_COMMIT;
        end
        S_COMMIT: state_q <= S_BSCAN;
        S_BSCAN: begin
          if (stat_i.done) begin
            state_q     <= S_OUT;
            out_valid_q <= 1'b1;
          end
        end
        S_OUT: begin
          if (out_ready_i) begin
            state_q     <= S_IDLE;
            out_valid_q <= 1'b0;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_ready_o   = (state_q == S_IDLE);
  assign out_valid_o  = out_valid_q;
  assign cmd_o.load   = accept;
  assign cmd_o.oscan  = (state_q == S_OSCAN);
  assign cmd_o.lscan  = (state_q == S_LSCAN);
  assign cmd_o.commit = (state_q == S_COMMIT);
  assign cmd_o.bscan  = (state_q == S_BSCAN);

  a_valid_in_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q == (state_q == S_OUT))
    else $error("result valid out of step with state");
  a_commit_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_COMMIT |=> state_q == S_BSCAN)
    else $error("commit not followed by snapshot scan");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |-> !out_valid_q)
    else $error("word taken while result pending");
endmodule

// ===== hdl/order_book_side_top.sv =====
`timescale 1ns / 1ps
// One side of a limit order book, aggregated by price level. Each word inserts an
// order, removes one by id, or asks for the volume strictly better than a price,
// and gives one result with status and a book snapshot. One word is handled at a
// time, and an output stall delays the next one. The time per word is set by the
// single read port of the order and level memories, swept one entry per cycle:
// insert and remove run order lookup, level lookup, commit, then the best-price
// and volume sweep (a rejected word skips level lookup and commit); query and
// no-op run only the sweep. book_side sits at address 0.
module order_book_side_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  obs_item_if.sink                     item_i,
  obs_result_if.source                 result_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [obs_pkg::PADDR_W-1:0]  paddr,
  input  logic [obs_pkg::PDATA_W-1:0]  pwdata,
  output logic [obs_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready
);
  import obs_pkg::*;

  logic     book_side_q;
  dp_cmd_t  cmd;
  dp_stat_t stat;

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      book_side_q <= 1'b0;
    end else if (psel && penable && pwrite && paddr == REG_BOOK_SIDE) begin
      book_side_q <= pwdata[0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr == REG_BOOK_SIDE) ? PDATA_W'(book_side_q) : '0;

  obs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (item_i.valid),
    .in_action_i (item_i.action),
    .in_ready_o  (item_i.ready),
    .out_valid_o (result_o.valid),
    .out_ready_i (result_o.ready),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  obs_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .book_side_i     (book_side_q),
    .action_i        (item_i.action),
    .order_id_i      (item_i.order_id),
    .price_i         (item_i.price),
    .quantity_i      (item_i.quantity),
    .status_o        (result_o.status),
    .best_price_o    (result_o.best_price),
    .book_empty_o    (result_o.book_empty),
    .total_volume_o  (result_o.total_volume),
    .order_count_o   (result_o.order_count),
    .level_count_o   (result_o.level_count),
    .better_volume_o (result_o.better_volume)
  );
endmodule

// ===== test/order_book_side_chk.sv =====
`timescale 1ns / 1ps
module order_book_side_chk (
  input  logic              clk_i,
  input  logic              rst_ni,
  obs_item_if               item_i,
  obs_result_if             result_i,
  input  logic              book_side_i,
  output int                fail_count_o,
  output int                pending_o
);
  import obs_pkg::*;

  typedef struct packed {
    stat_e              status;
    logic [PRICE_W-1:0] best_price;
    logic               book_empty;
    logic [VOL_W-1:0]   total_volume;
    logic [OCNT_W-1:0]  order_count;
    logic [LCNT_W-1:0]  level_count;
    logic [VOL_W-1:0]   better_volume;
  } snapshot_t;

  // shadow book
  logic               ord_used [MAX_ORDERS];
  logic [ID_W-1:0]    ord_key  [MAX_ORDERS];
  logic [PRICE_W-1:0] ord_px   [MAX_ORDERS];
  logic [QTY_W-1:0]   ord_qty  [MAX_ORDERS];
  logic               lvl_used [MAX_LEVELS];
  logic [PRICE_W-1:0] lvl_px   [MAX_LEVELS];
  logic [VOL_W-1:0]   lvl_vol  [MAX_LEVELS];
  int                 lvl_ords [MAX_LEVELS];
  logic [VOL_W-1:0]   vol_sum;
  int                 n_orders;
  int                 n_levels;

  snapshot_t snap_q[$];
  int mismatches;

  assign fail_count_o = mismatches;
  assign pending_o    = snap_q.size();

  function automatic bit px_better(logic [PRICE_W-1:0] a, logic [PRICE_W-1:0] b);
    return book_side_i ? (a < b) : (a > b);
  endfunction

  function automatic int find_ord(logic [ID_W-1:0] id);
    for (int i = 0; i < MAX_ORDERS; i++) if (ord_used[i] && ord_key[i] == id) return i;
    return -1;
  endfunction

  function automatic int find_lvl(logic [PRICE_W-1:0] p);
    for (int i = 0; i < MAX_LEVELS; i++) if (lvl_used[i] && lvl_px[i] == p) return i;
    return -1;
  endfunction

  function automatic stat_e book_insert(logic [ID_W-1:0] id, logic [PRICE_W-1:0] p,
                                        logic [QTY_W-1:0] q);
    int o;
    int l;
    o = -1;
    if (find_ord(id) >= 0) return ST_DUP;
    for (int i = 0; i < MAX_ORDERS; i++) if (!ord_used[i]) begin
      o = i;
      break;
    end
    if (o < 0) return ST_FULL;
    l = find_lvl(p);
    if (l < 0) begin
      for (int i = 0; i < MAX_LEVELS; i++) if (!lvl_used[i]) begin
        l = i;
        break;
      end
      if (l < 0) return ST_FULL;
      lvl_used[l] = 1'b1;
      lvl_px[l]   = p;
      lvl_vol[l]  = '0;
      lvl_ords[l] = 0;
      n_levels++;
    end
    lvl_vol[l] = lvl_vol[l] + VOL_W'(q);
    lvl_ords[l]++;
    ord_used[o] = 1'b1;
    ord_key[o]  = id;
    ord_px[o]   = p;
    ord_qty[o]  = q;
    n_orders++;
    vol_sum = vol_sum + VOL_W'(q);
    return ST_OK;
  endfunction

  function automatic stat_e book_remove(logic [ID_W-1:0] id);
    int o;
    int l;
    o = find_ord(id);
    if (o < 0) return ST_NOTFOUND;
    l = find_lvl(ord_px[o]);
    if (l >= 0) begin
      lvl_vol[l] = lvl_vol[l] - VOL_W'(ord_qty[o]);
      if (lvl_ords[l] > 0) lvl_ords[l]--;
      if (lvl_ords[l] == 0) begin
        lvl_used[l] = 1'b0;
        if (n_levels > 0) n_levels--;
      end
    end
    ord_used[o] = 1'b0;
    if (n_orders > 0) n_orders--;
    vol_sum = vol_sum - VOL_W'(ord_qty[o]);
    return ST_OK;
  endfunction

  function automatic snapshot_t book_apply(act_e act, logic [ID_W-1:0] id,
                                           logic [PRICE_W-1:0] p, logic [QTY_W-1:0] q);
    snapshot_t s;
    bit have;
    s = '0;
    s.status = ST_OK;
    have = 0;
    if (act == ACT_INSERT) s.status = book_insert(id, p, q);
    else if (act == ACT_REMOVE) s.status = book_remove(id);
    for (int i = 0; i < MAX_LEVELS; i++) begin
      if (!lvl_used[i]) continue;
      if (!have || px_better(lvl_px[i], s.best_price)) begin
        s.best_price = lvl_px[i];
        have = 1;
      end
      if (act == ACT_QUERY && px_better(lvl_px[i], p))
        s.better_volume = s.better_volume + lvl_vol[i];
    end
    s.book_empty   = !have;
    s.total_volume = vol_sum;
    s.order_count  = OCNT_W'(n_orders);
    s.level_count  = LCNT_W'(n_levels);
    return s;
  endfunction

  // predict on accepted input, compare on accepted output
  always @(posedge clk_i or negedge rst_ni) begin
    snapshot_t got;
    snapshot_t want;
    if (!rst_ni) begin
      for (int i = 0; i < MAX_ORDERS; i++) ord_used[i] = 1'b0;
      for (int i = 0; i < MAX_LEVELS; i++) lvl_used[i] = 1'b0;
      vol_sum = '0;
      n_orders = 0;
      n_levels = 0;
      snap_q.delete();
      mismatches = 0;
    end else begin
      if (item_i.valid && item_i.ready)
        snap_q.push_back(book_apply(act_e'(item_i.action), item_i.order_id,
                                    item_i.price, item_i.quantity));
      if (result_i.valid && result_i.ready) begin
        got.status        = stat_e'(result_i.status);
        got.best_price    = result_i.best_price;
        got.book_empty    = result_i.book_empty;
        got.total_volume  = result_i.total_volume;
        got.order_count   = result_i.order_count;
        got.level_count   = result_i.level_count;
        got.better_volume = result_i.better_volume;
        if (snap_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result word: %p", got);
        end else begin
          want = snap_q.pop_front();
          // every field is compared, best_price too; both sides give zero when the book is empty
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result mismatch: expected %p, got %p", want, got);
          end
        end
      end
    end
  end
endmodule

// ===== test/order_book_side_top_tb.sv =====
`timescale 1ns / 1ps
module order_book_side_top_tb;
  import obs_pkg::*;

  localparam int IDLE_LIMIT = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic pready;
  logic side_shadow = 1'b0;
  int   fail_count;
  int   pending;
  int   send_idle_pct;
  int   recv_idle_pct;
  int   quiet_cycles;
  bit   hold_off;

  obs_item_if   item_ch();
  obs_result_if result_ch();

  always #6 clk_i = ~clk_i;

  order_book_side_top dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .item_i(item_ch), .result_o(result_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  order_book_side_chk chk (
    .clk_i(clk_i), .rst_ni(rst_ni), .item_i(item_ch), .result_i(result_ch),
    .book_side_i(side_shadow), .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    item_ch.valid = 1'b0;
    item_ch.action = '0;
    item_ch.order_id = '0;
    item_ch.price = '0;
    item_ch.quantity = '0;
    result_ch.ready = 1'b0;
  end

  // receiver stalls
  always @(negedge clk_i)
    result_ch.ready <= rst_ni && ($urandom_range(99) >= recv_idle_pct);

  // watchdog on accepted traffic
  always @(posedge clk_i) begin
    if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready) || hold_off)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic set_side(input logic side);
    @(negedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= REG_BOOK_SIDE;
    pwdata <= PDATA_W'(side);
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    side_shadow = side;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // valid stays high into the next word when there is no idle gap
  task automatic send_word(input act_e act, input logic [31:0] id,
                           input logic [31:0] px, input logic [31:0] qty);
    while ($urandom_range(99) < send_idle_pct) begin
      item_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    item_ch.valid <= 1'b1;
    item_ch.action <= act;
    item_ch.order_id <= id;
    item_ch.price <= px;
    item_ch.quantity <= qty;
    do @(posedge clk_i); while (!item_ch.ready);
    @(negedge clk_i);
  endtask

  task automatic drain();
    item_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    hold_off = 1;
    repeat (450) @(negedge clk_i);
    hold_off = 0;
  endtask

  // mostly well-formed traffic with random ids and a small price pool
  task automatic random_words(input int n);
    logic [31:0] live_ids[$];
    logic [31:0] id;
    logic [31:0] px;
    int sel;
    int k;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(99);
      px = ($urandom_range(9) == 0) ? $urandom : 32'd1000 + $urandom_range(80);
      if (sel < 45) begin
        id = ($urandom_range(19) == 0 && live_ids.size() > 0) ?
             live_ids[$urandom_range(live_ids.size() - 1)] : $urandom;
        send_word(ACT_INSERT, id, px, $urandom_range(3) == 0 ? $urandom : $urandom_range(500));
        live_ids.push_back(id);
      end else if (sel < 75 && live_ids.size() > 0) begin
        k = $urandom_range(live_ids.size() - 1);
        send_word(ACT_REMOVE, live_ids[k], $urandom, $urandom);
        live_ids.delete(k);
      end else if (sel < 80) begin
        send_word(ACT_REMOVE, $urandom, $urandom, $urandom);
      end else if (sel < 97) begin
        send_word(ACT_QUERY, $urandom, px, $urandom);
      end else begin
        send_word(ACT_NOP, $urandom, $urandom, $urandom);
      end
    end
  endtask

  initial begin
    send_idle_pct = 0;
    recv_idle_pct = 0;
    quiet_cycles = 0;
    hold_off = 1;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    hold_off = 0;

    // directed: extremes, every action, special cases, both book sides
    send_word(ACT_QUERY, 32'd0, 32'd0, 32'd0);
    send_word(ACT_REMOVE, 32'd5, 32'd0, 32'd0);
    send_word(ACT_INSERT, 32'd0, 32'd0, 32'hFFFF_FFFF);
    send_word(ACT_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(ACT_INSERT, 32'hFFFF_FFFF, 32'd7, 32'd1);
    send_word(ACT_INSERT, 32'h5555_AAAA, 32'hFFFF_FFFF, 32'd0);
    send_word(ACT_INSERT, 32'hAAAA_5555, 32'h8000_0000, 32'h5555_AAAA);
    send_word(ACT_QUERY, 32'd0, 32'h8000_0000, 32'd0);
    send_word(ACT_QUERY, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF);
    send_word(ACT_NOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(ACT_REMOVE, 32'hFFFF_FFFF, 32'd0, 32'd0);
    drain();
    set_side(1'b1);
    send_word(ACT_QUERY, 32'd0, 32'hFFFF_FFFF, 32'd0);
    send_word(ACT_QUERY, 32'd0, 32'h8000_0000, 32'd0);
    // fill the level table, then overflow it
    for (int i = 0; i < MAX_LEVELS; i++) send_word(ACT_INSERT, 32'h100 + i, 32'd50 + i, 32'd3);
    send_word(ACT_INSERT, 32'h1000, 32'd9, 32'd1);
    // fill the order table on existing levels, then overflow it
    for (int i = 0; i < MAX_ORDERS; i++) send_word(ACT_INSERT, 32'h2000 + i, 32'd60, 32'd2);
    send_word(ACT_INSERT, 32'h9000, 32'd60, 32'd1);
    send_word(ACT_QUERY, 32'd0, 32'd70, 32'd0);
    for (int i = 0; i < MAX_ORDERS; i++) send_word(ACT_REMOVE, 32'h2000 + i, 32'd0, 32'd0);
    for (int i = 0; i < MAX_LEVELS; i++) send_word(ACT_REMOVE, 32'h100 + i, 32'd0, 32'd0);
    for (int i = 0; i < 4; i++)
      send_word(ACT_REMOVE, i == 0 ? 32'd0 : 32'hFFFF_FFFF, 32'd0, 32'd0);
    drain();

    // random phases
    send_idle_pct = 17;
    recv_idle_pct = 49;
    set_side(1'b0);
    random_words(280);
    drain();
    send_idle_pct = 49;
    recv_idle_pct = 17;
    set_side(1'b1);
    random_words(280);
    drain();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_side(1'b0);
    random_words(280);
    drain();

    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
